// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL; used by switch_to_midi_message_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, masked while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, no reset mask.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/swmidi_pkg.sv =====
// Package: codes, register indexes, message types and helpers for the switch-to-MIDI block.
`default_nettype none
package swmidi_pkg;

  // Item opcodes (carried in s_tuser)
  localparam logic [2:0] OP_PRESS   = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_POLL    = 3'd2;
  localparam logic [2:0] OP_RESEND  = 3'd3;
  localparam logic [2:0] OP_WRITE   = 3'd4;

  // Switch modes
  localparam logic [2:0] MODE_MOMENTARY = 3'd0;
  localparam logic [2:0] MODE_LATCH     = 3'd1;
  localparam logic [2:0] MODE_TRIGGER   = 3'd2;
  localparam logic [2:0] MODE_NOTE      = 3'd3;
  localparam logic [2:0] MODE_DRUM      = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_SWITCH_MODE    = 3'd0;
  localparam logic [2:0] REG_CONTROL_NUMBER = 3'd1;
  localparam logic [2:0] REG_SHIFT_NUMBER   = 3'd2;
  localparam logic [2:0] REG_OUT_HIGH       = 3'd3;
  localparam logic [2:0] REG_OUT_LOW        = 3'd4;
  localparam logic [2:0] REG_CHANNEL_NUMBER = 3'd5;
  localparam logic [2:0] REG_ON_MESSAGE     = 3'd6;
  localparam logic [2:0] REG_OFF_MESSAGE    = 3'd7;

  // MIDI status types
  localparam logic [7:0] NOTE_ON_TYPE  = 8'h90;
  localparam logic [7:0] NOTE_OFF_TYPE = 8'h80;
  localparam logic [7:0] CC_TYPE       = 8'hB0;

  localparam logic [7:0] DRUM_HOLD_MS = 8'd50;
  localparam logic [7:0] MS_MAX       = 8'd255;
  localparam logic [8:0] RET_NONE     = 9'h1FF;
  localparam logic [8:0] RET_REALTIME = 9'd1;

  localparam int CFG_WIDTH = 24;

  typedef struct packed {
    logic [8:0] return_value;
    logic [4:0] msg_channel;
    logic [7:0] msg_data2;
    logic [7:0] msg_data1;
    logic [7:0] msg_status;
  } result_t;

  function automatic logic is_realtime(input logic [7:0] n);
    is_realtime = (n == 8'hF8) || (n == 8'hFA) || (n == 8'hFB) ||
                  (n == 8'hFC) || (n == 8'hFF);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/switch_to_midi_message_top.sv =====
// Top level: switch events in, MIDI message fields out, with configuration registers.
// Registered: result in the output register in the cycle after the input transfer.
// Throughput: 1 item per cycle if not stalled; one pass over latch flag and timer.
// s_tready is high whenever the output register is empty or being drained.
// Reset (rst, synchronous): registers take their default values, latch flag off,
// timer zero, output register empty.
`default_nettype none
`include "assert_macros.svh"
module switch_to_midi_message_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [2:0]                        cfg_index,
  input  wire logic [swmidi_pkg::CFG_WIDTH-1:0]  cfg_data,
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  // [0] shift_active, [1] latch_value, [9:2] ms_elapsed, [15:10] zero
  input  wire logic [15:0]                       s_tdata,
  // [2:0] opcode
  input  wire logic [2:0]                        s_tuser,
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  // [7:0] msg_status, [15:8] msg_data1, [23:16] msg_data2, [28:24] msg_channel,
  // [37:29] return_value, [39:38] zero
  output      logic [39:0]                       m_tdata,
  // [0] msg_valid
  output      logic [0:0]                        m_tuser
);

  logic [2:0]  switch_mode;
  logic [7:0]  control_number;
  logic [7:0]  shift_number;
  logic [6:0]  out_high;
  logic [6:0]  out_low;
  logic [4:0]  channel_number;
  logic [23:0] on_message;
  logic [23:0] off_message;

  logic        latched_on, latched_on_next;
  logic [7:0]  ms_since_on, ms_since_on_next;

  swmidi_pkg::result_t res, res_next;
  logic                msg_valid, msg_valid_next;

  logic       accept;
  logic [2:0] opcode;
  logic       shift_active;
  logic       latch_value;
  logic [7:0] ms_elapsed;
  logic [8:0] ms_sum;
  logic [7:0] ms_sat;
  logic       rt;
  logic [7:0] num;
  logic       on_custom, off_custom;
  logic       as_note;

  assign opcode       = s_tuser;
  assign shift_active = s_tdata[0];
  assign latch_value  = s_tdata[1];
  assign ms_elapsed   = s_tdata[9:2];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign ms_sum = {1'b0, ms_since_on} + {1'b0, ms_elapsed};
  assign ms_sat = ms_sum[8] ? swmidi_pkg::MS_MAX : ms_sum[7:0];

  assign rt         = swmidi_pkg::is_realtime(control_number);
  assign num        = (shift_active && shift_number != 8'd0) ? shift_number : control_number;
  assign on_custom  = on_message[23:16] != 8'd0;
  assign off_custom = off_message[23:16] != 8'd0;

  // Decision for one item; do_on/do_off follow the on and off message rules.
  always_comb begin
    logic emit;
    logic do_on;
    logic do_off;
    logic [7:0] st, d1, d2;
    emit   = 1'b0;
    do_on  = 1'b0;
    do_off = 1'b0;
    st     = 8'd0;
    d1     = 8'd0;
    d2     = 8'd0;
    as_note = 1'b0;
    latched_on_next  = latched_on;
    ms_since_on_next = ms_sat;
    res_next.return_value = swmidi_pkg::RET_NONE;

    if (opcode == swmidi_pkg::OP_WRITE) begin
      latched_on_next = latch_value;
    end else if (opcode == swmidi_pkg::OP_RESEND) begin
      emit = 1'b1;
      if (rt) begin
        st = control_number;
      end else begin
        st = swmidi_pkg::CC_TYPE;
        d1 = control_number;
        d2 = {1'b0, latched_on ? out_high : out_low};
      end
      res_next.return_value = {2'b00, latched_on ? out_high : out_low};
    end else if (opcode == swmidi_pkg::OP_PRESS) begin
      if (!latched_on) begin
        do_on   = 1'b1;
        as_note = (switch_mode == swmidi_pkg::MODE_NOTE) ||
                  (switch_mode == swmidi_pkg::MODE_DRUM);
        ms_since_on_next = 8'd0;
        latched_on_next  = 1'b1;
      end else if (switch_mode == swmidi_pkg::MODE_TRIGGER ||
                   switch_mode == swmidi_pkg::MODE_DRUM) begin
        do_on   = 1'b1;
        as_note = switch_mode == swmidi_pkg::MODE_DRUM;
      end else begin
        do_off = 1'b1;
        latched_on_next = 1'b0;
      end
    end else if (opcode == swmidi_pkg::OP_RELEASE &&
                 (switch_mode == swmidi_pkg::MODE_MOMENTARY ||
                  switch_mode == swmidi_pkg::MODE_NOTE)) begin
      do_off = 1'b1;
      latched_on_next = 1'b0;
    end else begin
      // poll, unused opcodes, release in latching modes: drum auto-clear after the hold time
      if (latched_on && switch_mode == swmidi_pkg::MODE_DRUM &&
          ms_sat > swmidi_pkg::DRUM_HOLD_MS) begin
        latched_on_next = 1'b0;
      end
    end

    if (do_on) begin
      emit = 1'b1;
      priority if (on_custom) begin
        st = on_message[23:16];
        d1 = on_message[15:8];
        d2 = on_message[7:0];
      end else if (rt) begin
        st = control_number;
      end else begin
        st = as_note ? swmidi_pkg::NOTE_ON_TYPE : swmidi_pkg::CC_TYPE;
        d1 = num;
        d2 = {1'b0, out_high};
      end
      res_next.return_value = rt ? swmidi_pkg::RET_REALTIME : {1'b0, num};
    end

    if (do_off) begin
      priority if (off_custom) begin
        emit = 1'b1;
        st = off_message[23:16];
        d1 = off_message[15:8];
        d2 = off_message[7:0];
      end else if (!rt) begin
        emit = 1'b1;
        st = (switch_mode == swmidi_pkg::MODE_NOTE) ? swmidi_pkg::NOTE_OFF_TYPE
                                                    : swmidi_pkg::CC_TYPE;
        d1 = num;
        d2 = {1'b0, out_low};
      end
      res_next.return_value = {2'b00, out_low};
    end

    msg_valid_next       = emit;
    res_next.msg_status  = st;
    res_next.msg_data1   = d1;
    res_next.msg_data2   = d2;
    res_next.msg_channel = emit ? channel_number : 5'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_mode    <= swmidi_pkg::MODE_MOMENTARY;
      control_number <= 8'd0;
      shift_number   <= 8'd0;
      out_high       <= 7'd127;
      out_low        <= 7'd0;
      channel_number <= 5'd1;
      on_message     <= 24'd0;
      off_message    <= 24'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swmidi_pkg::REG_SWITCH_MODE:    switch_mode    <= cfg_data[2:0];
        swmidi_pkg::REG_CONTROL_NUMBER: control_number <= cfg_data[7:0];
        swmidi_pkg::REG_SHIFT_NUMBER:   shift_number   <= cfg_data[7:0];
        swmidi_pkg::REG_OUT_HIGH:       out_high       <= cfg_data[6:0];
        swmidi_pkg::REG_OUT_LOW:        out_low        <= cfg_data[6:0];
        swmidi_pkg::REG_CHANNEL_NUMBER: channel_number <= cfg_data[4:0];
        swmidi_pkg::REG_ON_MESSAGE:     on_message     <= cfg_data[23:0];
        swmidi_pkg::REG_OFF_MESSAGE:    off_message    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_on  <= 1'b0;
      ms_since_on <= 8'd0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        latched_on  <= latched_on_next;
        ms_since_on <= ms_since_on_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res       <= res_next;
      msg_valid <= msg_valid_next;
    end
  end

  assign m_tdata = {2'b00, res};
  assign m_tuser = msg_valid;

  `ASSERT_CLK(a_idle_fields_zero,
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[28:0] == 29'd0),
    "fields set without a message")
  `ASSERT_CLK(a_msg_has_return,
    (m_tvalid && m_tuser[0]) |-> (m_tdata[37:29] != swmidi_pkg::RET_NONE),
    "message with no return value")
  `ASSERT_CLK(a_press_turns_on,
    (accept && opcode == swmidi_pkg::OP_PRESS && !latched_on) |=>
      (latched_on && ms_since_on == 8'd0),
    "press did not latch or clear timer")
  `ASSERT_CLK(a_write_state,
    (accept && opcode == swmidi_pkg::OP_WRITE) |=> (latched_on == $past(latch_value)),
    "write did not set latch flag")
  `ASSERT_CLK(a_timer_hold, (!accept) |=> $stable(ms_since_on),
    "timer moved without a transfer")

endmodule
`default_nettype wire

// ===== verif/switch_to_midi_message_top_test.sv =====
// Self-checking testbench for switch_to_midi_message_top: predicted MIDI messages vs stream output.
import swmidi_pkg::*;

typedef struct packed {
  logic       valid;
  logic [7:0] status;
  logic [7:0] data1;
  logic [7:0] data2;
  logic [4:0] chan;
  logic [8:0] ret;
} midi_msg_t;

class midi_scoreboard;
  logic [2:0]  mode;
  logic [7:0]  ctrl_num;
  logic [7:0]  shift_num;
  logic [6:0]  out_hi;
  logic [6:0]  out_lo;
  logic [4:0]  chan;
  logic [23:0] on_msg;
  logic [23:0] off_msg;
  logic        latched;
  logic [7:0]  ms_timer;
  midi_msg_t   pending_q[$];
  int          errors;

  function new();
    mode = MODE_MOMENTARY;
    ctrl_num = 8'd0;
    shift_num = 8'd0;
    out_hi = 7'd127;
    out_lo = 7'd0;
    chan = 5'd1;
    on_msg = 24'd0;
    off_msg = 24'd0;
    latched = 1'b0;
    ms_timer = 8'd0;
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [23:0] val);
    case (idx)
      REG_SWITCH_MODE:    mode = val[2:0];
      REG_CONTROL_NUMBER: ctrl_num = val[7:0];
      REG_SHIFT_NUMBER:   shift_num = val[7:0];
      REG_OUT_HIGH:       out_hi = val[6:0];
      REG_OUT_LOW:        out_lo = val[6:0];
      REG_CHANNEL_NUMBER: chan = val[4:0];
      REG_ON_MESSAGE:     on_msg = val;
      REG_OFF_MESSAGE:    off_msg = val;
      default: ;
    endcase
  endfunction

  function midi_msg_t make_msg(logic [7:0] st, logic [7:0] d1, logic [7:0] d2);
    midi_msg_t m;
    m = '0;
    m.valid = 1'b1;
    m.status = st;
    m.data1 = d1;
    m.data2 = d2;
    return m;
  endfunction

  function midi_msg_t on_msg_for(logic rt, logic [7:0] num, logic as_note);
    if (on_msg[23:16] != 8'd0) return make_msg(on_msg[23:16], on_msg[15:8], on_msg[7:0]);
    if (rt) return make_msg(ctrl_num, 8'd0, 8'd0);
    return make_msg(as_note ? NOTE_ON_TYPE : CC_TYPE, num, {1'b0, out_hi});
  endfunction

  // real-time numbers send nothing on the off side without a custom message
  function midi_msg_t off_msg_for(logic rt, logic [7:0] num);
    if (off_msg[23:16] != 8'd0)
      return make_msg(off_msg[23:16], off_msg[15:8], off_msg[7:0]);
    if (!rt) return make_msg(mode == MODE_NOTE ? NOTE_OFF_TYPE : CC_TYPE, num, {1'b0, out_lo});
    return '0;
  endfunction

  function void note_event(logic [2:0] op, logic sh, logic lv, logic [7:0] ms);
    midi_msg_t  m;
    logic       rt;
    logic [7:0] num;
    logic [8:0] sum;
    logic [8:0] ret;
    m = '0;
    ret = RET_NONE;
    rt = (ctrl_num == 8'hF8) || (ctrl_num == 8'hFA) || (ctrl_num == 8'hFB) ||
         (ctrl_num == 8'hFC) || (ctrl_num == 8'hFF);
    num = (sh && shift_num != 8'd0) ? shift_num : ctrl_num;
    sum = {1'b0, ms_timer} + {1'b0, ms};
    ms_timer = sum[8] ? MS_MAX : sum[7:0];
    if (op == OP_WRITE) begin
      latched = lv;
    end else if (op == OP_RESEND) begin
      if (rt) m = make_msg(ctrl_num, 8'd0, 8'd0);
      else m = make_msg(CC_TYPE, ctrl_num, {1'b0, latched ? out_hi : out_lo});
      ret = {2'b0, latched ? out_hi : out_lo};
    end else if (op == OP_PRESS) begin
      if (!latched) begin
        m = on_msg_for(rt, num, mode == MODE_NOTE || mode == MODE_DRUM);
        ms_timer = 8'd0;
        latched = 1'b1;
        ret = rt ? RET_REALTIME : {1'b0, num};
      end else if (mode == MODE_TRIGGER || mode == MODE_DRUM) begin
        m = on_msg_for(rt, num, mode == MODE_DRUM);
        ret = rt ? RET_REALTIME : {1'b0, num};
      end else begin
        m = off_msg_for(rt, num);
        latched = 1'b0;
        ret = {2'b0, out_lo};
      end
    end else if (op == OP_RELEASE && (mode == MODE_MOMENTARY || mode == MODE_NOTE)) begin
      m = off_msg_for(rt, num);
      latched = 1'b0;
      ret = {2'b0, out_lo};
    end else begin
      // poll, unused opcodes, release in latching modes: drum auto-clear
      if (latched && mode == MODE_DRUM && ms_timer > DRUM_HOLD_MS) latched = 1'b0;
    end
    m.ret = ret;
    m.chan = m.valid ? chan : 5'd0;
    pending_q.push_back(m);
  endfunction

  function void check_message(logic [0:0] user, logic [39:0] data);
    midi_msg_t  e;
    logic [8:0] exp_v[6];
    logic [8:0] act_v[6];
    string      field_name[6];
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected message tuser=%h tdata=%h", $time, user, data);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    field_name = '{"msg_valid", "msg_status", "msg_data1", "msg_data2", "msg_channel",
                   "return_value"};
    exp_v = '{{8'd0, e.valid}, {1'b0, e.status}, {1'b0, e.data1}, {1'b0, e.data2},
              {4'd0, e.chan}, e.ret};
    act_v = '{{8'd0, user[0]}, {1'b0, data[7:0]}, {1'b0, data[15:8]}, {1'b0, data[23:16]},
              {4'd0, data[28:24]}, data[37:29]};
    for (int i = 0; i < 6; i++) begin
      if (exp_v[i] !== act_v[i]) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field_name[i],
                 exp_v[i], act_v[i]);
        errors++;
      end
    end
  endfunction
endclass

module switch_to_midi_message_top_test;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  wire logic   s_tready;
  logic [15:0] s_tdata = 16'd0;
  logic [2:0]  s_tuser = 3'd0;
  wire logic   m_tvalid;
  logic        m_tready = 1'b0;
  wire logic [39:0] m_tdata;
  wire logic [0:0]  m_tuser;
  logic        hold_sink = 1'b0;
  midi_scoreboard sb;

  switch_to_midi_message_top DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_event(logic [2:0] op, logic sh, logic lv, logic [7:0] ms);
    logic acc;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {6'd0, ms, lv, sh};
    acc = 1'b0;
    while (!acc) begin
      @(negedge clk);
      acc = s_tready;
      if (acc) sb.note_event(op, sh, lv, ms);
      @(posedge clk);
    end
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    cfg_we <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic random_config(int k);
    logic [7:0]  ctrl;
    logic [23:0] on_v;
    logic [23:0] off_v;
    int          r;
    if (k == 0) begin
      write_reg(REG_SWITCH_MODE, 24'(MODE_MOMENTARY));
      write_reg(REG_CONTROL_NUMBER, 24'd0);
      write_reg(REG_SHIFT_NUMBER, 24'd0);
      write_reg(REG_OUT_HIGH, 24'd0);
      write_reg(REG_OUT_LOW, 24'd0);
      write_reg(REG_CHANNEL_NUMBER, 24'd1);
      write_reg(REG_ON_MESSAGE, 24'd0);
      write_reg(REG_OFF_MESSAGE, 24'd0);
    end else if (k == 1) begin
      write_reg(REG_SWITCH_MODE, 24'(MODE_DRUM));
      write_reg(REG_CONTROL_NUMBER, 24'd255);
      write_reg(REG_SHIFT_NUMBER, 24'd255);
      write_reg(REG_OUT_HIGH, 24'd127);
      write_reg(REG_OUT_LOW, 24'd127);
      write_reg(REG_CHANNEL_NUMBER, 24'd16);
      write_reg(REG_ON_MESSAGE, 24'hFFFFFF);
      write_reg(REG_OFF_MESSAGE, 24'hFFFFFF);
    end else begin
      r = $urandom_range(0, 99);
      write_reg(REG_SWITCH_MODE, r < 90 ? 24'($urandom_range(0, 4)) : 24'($urandom_range(5, 7)));
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 4))
        0: ctrl = 8'hF8;
        1: ctrl = 8'hFA;
        2: ctrl = 8'hFB;
        3: ctrl = 8'hFC;
        default: ctrl = 8'hFF;
      endcase
      if (r >= 25) ctrl = (r < 35) ? 8'd0 : 8'($urandom_range(0, 255));
      write_reg(REG_CONTROL_NUMBER, 24'(ctrl));
      write_reg(REG_SHIFT_NUMBER, $urandom_range(0, 1) ? 24'd0 : 24'($urandom_range(0, 255)));
      write_reg(REG_OUT_HIGH, 24'($urandom_range(0, 127)));
      write_reg(REG_OUT_LOW, 24'($urandom_range(0, 127)));
      r = $urandom_range(0, 99);
      write_reg(REG_CHANNEL_NUMBER,
                r < 85 ? 24'($urandom_range(1, 16)) : 24'($urandom_range(0, 31)));
      on_v = 24'($urandom_range(0, 24'hFFFFFF));
      off_v = 24'($urandom_range(0, 24'hFFFFFF));
      if ($urandom_range(0, 1)) on_v[23:16] = 8'd0;
      if ($urandom_range(0, 1)) off_v[23:16] = 8'd0;
      write_reg(REG_ON_MESSAGE, on_v);
      write_reg(REG_OFF_MESSAGE, off_v);
    end
  endtask

  // result sink with random back-pressure and one long hold on request
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        hold_sink = 1'b0;
        n = 300;
      end else if ($urandom_range(0, 9) < 7) begin
        m_tready <= 1'b1;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      end else begin
        m_tready <= 1'b0;
        n = 1 + gap_len();
      end
      repeat (n) @(posedge clk);
    end
  end

  // values are stable between the falling edge and the transfer edge
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_message(m_tuser, m_tdata);
  end

  initial begin
    #10_000_000;
    $display("switch_to_midi_message_top_test: errors");
    $finish;
  end

  initial begin
    logic [2:0] op;
    logic [7:0] ms;
    int         r;
    int         n;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: momentary, CC 0, high 127, low 0
    send_event(OP_PRESS, 1'b0, 1'b0, 8'd0);
    send_event(OP_RELEASE, 1'b1, 1'b1, 8'd255);
    send_event(OP_RESEND, 1'b0, 1'b0, 8'd0);
    send_event(OP_WRITE, 1'b0, 1'b1, 8'd3);
    send_event(OP_RESEND, 1'b1, 1'b0, 8'd255);
    send_event(OP_POLL, 1'b0, 1'b0, 8'd0);
    send_event(3'd5, 1'b1, 1'b1, 8'd17);
    send_event(3'd7, 1'b1, 1'b0, 8'd200);
    drain();

    // drum timing around the hold time, shift number in use
    write_reg(REG_SWITCH_MODE, 24'(MODE_DRUM));
    write_reg(REG_CONTROL_NUMBER, 24'd36);
    write_reg(REG_SHIFT_NUMBER, 24'd255);
    write_reg(REG_OUT_HIGH, 24'd127);
    write_reg(REG_OUT_LOW, 24'd0);
    write_reg(REG_CHANNEL_NUMBER, 24'd16);
    write_reg(REG_ON_MESSAGE, 24'd0);
    write_reg(REG_OFF_MESSAGE, 24'd0);
    cfg_we <= 1'b0;
    send_event(OP_PRESS, 1'b1, 1'b0, 8'd0);
    send_event(OP_POLL, 1'b0, 1'b0, 8'd50);
    send_event(OP_POLL, 1'b0, 1'b0, 8'd1);
    send_event(OP_PRESS, 1'b0, 1'b0, 8'd255);
    send_event(OP_RELEASE, 1'b0, 1'b0, 8'd0);
    drain();

    // unused mode, real-time number with custom off, out-of-range channel
    write_reg(REG_SWITCH_MODE, 24'd7);
    write_reg(REG_CONTROL_NUMBER, 24'hFF);
    write_reg(REG_OUT_HIGH, 24'd0);
    write_reg(REG_OUT_LOW, 24'd127);
    write_reg(REG_CHANNEL_NUMBER, 24'd0);
    write_reg(REG_OFF_MESSAGE, 24'hFFFFFF);
    cfg_we <= 1'b0;
    send_event(OP_PRESS, 1'b0, 1'b0, 8'd10);
    send_event(OP_PRESS, 1'b1, 1'b0, 8'd10);
    send_event(OP_RESEND, 1'b0, 1'b0, 8'd0);
    send_event(OP_RELEASE, 1'b0, 1'b0, 8'd0);
    drain();

    // real-time number in note mode with no custom off: off side is silent
    write_reg(REG_SWITCH_MODE, 24'(MODE_NOTE));
    write_reg(REG_CONTROL_NUMBER, 24'hFA);
    write_reg(REG_CHANNEL_NUMBER, 24'd31);
    write_reg(REG_OFF_MESSAGE, 24'd0);
    write_reg(REG_ON_MESSAGE, 24'h00_12_34);
    cfg_we <= 1'b0;
    send_event(OP_PRESS, 1'b0, 1'b0, 8'd0);
    send_event(OP_PRESS, 1'b0, 1'b0, 8'd0);
    send_event(OP_RESEND, 1'b0, 1'b0, 8'd0);
    drain();

    for (int k = 0; k < 30; k++) begin
      random_config(k);
      cfg_we <= 1'b0;
      for (int i = 0; i < 60; i++) begin
        r = $urandom_range(0, 99);
        if (r < 35) op = OP_PRESS;
        else if (r < 60) op = OP_RELEASE;
        else if (r < 78) op = OP_POLL;
        else if (r < 88) op = OP_RESEND;
        else if (r < 96) op = OP_WRITE;
        else op = 3'($urandom_range(5, 7));
        r = $urandom_range(0, 99);
        if (r < 50) ms = 8'($urandom_range(0, 20));
        else if (r < 75) ms = 8'($urandom_range(40, 60));
        else if (r < 92) ms = 8'($urandom_range(0, 255));
        else ms = 8'd255;
        if (k == 5 && i == 10) hold_sink = 1'b1;
        send_event(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), ms);
        if ($urandom_range(0, 99) == 0) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (sb.pending_q.size() != 0) @(posedge clk);
        end else if (k % 4 != 3) begin
          idle_sender(gap_len());
        end
      end
      drain();
    end

    s_tvalid <= 1'b0;
    for (n = 0; n < 2000 && sb.pending_q.size() != 0; n++) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.pending_q.size() != 0) begin
      $display("%0t: %0d expected messages never arrived", $time, sb.pending_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("switch_to_midi_message_top_test: clean");
    end else begin
      $display("switch_to_midi_message_top_test: errors");
    end
    $finish;
  end
endmodule

// ===== switch_to_midi_message_top.f =====
+incdir+hw/rtl
hw/rtl/swmidi_pkg.sv
hw/rtl/switch_to_midi_message_top.sv
verif/switch_to_midi_message_top_test.sv
